/* hw/rtl/u16u8_pkg.sv */
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
`timescale 1ns / 1ps
`default_nettype none

package u16u8_pkg;

    // Kind of bytes that the current word produces once any held unit is flushed.
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_ZERO  = 3'd1;
    localparam logic [2:0] KIND_ONE   = 3'd2;
    localparam logic [2:0] KIND_TWO   = 3'd3;
    localparam logic [2:0] KIND_THREE = 3'd4;
    localparam logic [2:0] KIND_PAIR  = 3'd5;

    localparam logic [15:0] MASK_ONE   = 16'hFF80;
    localparam logic [15:0] MASK_TWO   = 16'hF800;
    localparam logic [15:0] MASK_SURR  = 16'hFC00;
    localparam logic [15:0] HIGH_SURR  = 16'hD800;
    localparam logic [15:0] LOW_SURR   = 16'hDC00;

    // One queued job for the byte serializer.
    typedef struct packed {
        logic        flush;
        logic [15:0] held;
        logic [2:0]  kind;
        logic [15:0] unit;
    } entry_t;

    // Byte idx (0..2) of the three-byte form of a 16-bit unit.
    function automatic logic [7:0] three_byte(input logic [15:0] x, input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = {4'b1110, x[15:12]};
            2'd1:    b = {2'b10, x[11:6]};
            default: b = {2'b10, x[5:0]};
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/u16u8_front.sv */
// Front end: byte swap, surrogate tracking and classification of each word.
`timescale 1ns / 1ps
`default_nettype none

module u16u8_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [15:0]          s_code_unit,
    output logic                      push,
    output u16u8_pkg::entry_t         push_entry,
    input  wire logic                 queue_full
);
    import u16u8_pkg::*;

    logic        swap_reg;
    logic        pending_reg, pending_next;
    logic [15:0] held_reg, held_next;
    logic [15:0] u;
    logic        accept;
    logic [2:0]  kind;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;
    assign u       = swap_reg ? {s_code_unit[7:0], s_code_unit[15:8]} : s_code_unit;

    always_comb begin
        pending_next = pending_reg;
        held_next    = held_reg;
        if (u == 16'd0) begin
            kind = KIND_ZERO;
        end else if ((u & MASK_ONE) == 16'd0) begin
            kind = KIND_ONE;
        end else if ((u & MASK_TWO) == 16'd0) begin
            kind = KIND_TWO;
        end else if ((u & MASK_SURR) == HIGH_SURR) begin
            kind = KIND_NONE;
        end else begin
            kind = KIND_THREE;
        end

        push_entry.held = held_reg;
        push_entry.unit = u;
        push_entry.flush = 1'b0;
        push_entry.kind  = kind;
        if (pending_reg && ((u & MASK_SURR) == LOW_SURR)) begin
            push_entry.kind = KIND_PAIR;
        end else if (pending_reg) begin
            push_entry.flush = 1'b1;
        end

        if (accept) begin
            // A high surrogate is held unless it completes a pair; anything else clears.
            if (push_entry.kind == KIND_NONE) begin
                pending_next = 1'b1;
                held_next    = u;
            end else begin
                pending_next = 1'b0;
                held_next    = 16'd0;
            end
        end
    end

    assign push = accept && (push_entry.flush || (push_entry.kind != KIND_NONE));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swap_reg    <= 1'b1;
            pending_reg <= 1'b0;
            held_reg    <= 16'd0;
        end else begin
            if (cfg_we) begin
                swap_reg <= cfg_wdata;
            end
            pending_reg <= pending_next;
            held_reg    <= held_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/u16u8_fifo.sv */
// Small queue of classified words between the front end and the serializer.
`timescale 1ns / 1ps
`default_nettype none

module u16u8_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire u16u8_pkg::entry_t    push_entry,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      head_valid,
    output u16u8_pkg::entry_t         head_entry
);
    import u16u8_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    entry_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_entry = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/u16u8_back.sv */
// Back end: turns a queued job into UTF-8 bytes, one per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module u16u8_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 head_valid,
    input  wire u16u8_pkg::entry_t    head_entry,
    output logic                      pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [7:0]                m_out_byte,
    output logic                      m_last,
    output logic                      m_string_end
);
    import u16u8_pkg::*;

    logic [2:0]  step_reg;
    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg, end_reg;

    logic [2:0]  base;
    logic [2:0]  total;
    logic [2:0]  kind_cnt;
    logic [2:0]  idx;
    logic [20:0] pair_cp;
    logic [7:0]  byte_next;
    logic        end_next;
    logic        last_next;
    logic        load;

    // The pair's code point: ((high & 0x3FF) + 0x40) << 10 | (low & 0x3FF).
    assign pair_cp = {(11'(head_entry.held[9:0]) + 11'h040), head_entry.unit[9:0]};

    always_comb begin
        base = head_entry.flush ? 3'd3 : 3'd0;
        unique case (head_entry.kind)
            KIND_ZERO:  kind_cnt = 3'd1;
            KIND_ONE:   kind_cnt = 3'd1;
            KIND_TWO:   kind_cnt = 3'd2;
            KIND_THREE: kind_cnt = 3'd3;
            KIND_PAIR:  kind_cnt = 3'd4;
            default:    kind_cnt = 3'd0;
        endcase
        total    = base + kind_cnt;
        idx      = step_reg - base;
        end_next = 1'b0;

        if (step_reg < base) begin
            byte_next = three_byte(head_entry.held, step_reg[1:0]);
        end else begin
            unique case (head_entry.kind)
                KIND_ZERO: begin
                    byte_next = 8'd0;
                    end_next  = 1'b1;
                end
                KIND_ONE: byte_next = head_entry.unit[7:0];
                KIND_TWO: begin
                    byte_next = (idx == 3'd0) ? {3'b110, head_entry.unit[10:6]}
                                              : {2'b10, head_entry.unit[5:0]};
                end
                KIND_THREE: byte_next = three_byte(head_entry.unit, idx[1:0]);
                KIND_PAIR: begin
                    case (idx)
                        3'd0:    byte_next = {5'b11110, pair_cp[20:18]};
                        3'd1:    byte_next = {2'b10, pair_cp[17:12]};
                        3'd2:    byte_next = {2'b10, pair_cp[11:6]};
                        default: byte_next = {2'b10, pair_cp[5:0]};
                    endcase
                end
                default: byte_next = 8'd0;
            endcase
        end
        last_next = (step_reg == total - 3'd1);
    end

    assign load = head_valid && (!valid_reg || m_ready);
    assign pop  = load && last_next;

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= byte_next;
            last_reg <= last_next;
            end_reg  <= end_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            step_reg  <= 3'd0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                step_reg  <= last_next ? 3'd0 : step_reg + 3'd1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = valid_reg;
    assign m_out_byte   = byte_reg;
    assign m_last       = last_reg;
    assign m_string_end = end_reg;

endmodule

`default_nettype wire

/* hw/rtl/utf16_to_utf8_transcoder_top.sv */
// Top level of the UTF-16 to UTF-8 transcoder.
//
// Input channel (s_valid/s_ready, s_code_unit) takes one UTF-16 word per cycle
// while the queue is not full; output channel (m_valid/m_ready) gives one
// UTF-8 byte per cycle while m_ready is high, with m_last on the final byte
// of a word and m_string_end on the zero terminator. cfg_we/cfg_wdata write
// the byte-swap control; write it only while idle. The front end classifies
// each word and tracks a held high surrogate; a queue of FIFO_DEPTH entries
// decouples it from the byte serializer. A word that produces bytes is
// registered in the queue and then in the serializer's output register
// before its first byte shows. Throughput is set by the serializer's single
// output register: one byte per cycle while m_ready is high. A word yields
// from zero bytes (a held high surrogate) up to six (when a held unit is
// flushed). While m_ready is low the output byte holds and the queue fills;
// s_ready drops only when the queue is full. Reset clears the queue, the
// held surrogate and the output valid flag, and sets byte swapping on.
`timescale 1ns / 1ps
`default_nettype none

module utf16_to_utf8_transcoder_top #(
    parameter int FIFO_DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_code_unit,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_last,
    output logic             m_string_end
);
    import u16u8_pkg::*;

    logic   push, queue_full, pop, head_valid;
    entry_t push_entry, head_entry;

    u16u8_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_unit (s_code_unit),
        .push        (push),
        .push_entry  (push_entry),
        .queue_full  (queue_full)
    );

    u16u8_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    u16u8_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_last       (m_last),
        .m_string_end (m_string_end)
    );

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the UTF-16 to UTF-8 transcoder top level.
`timescale 1ns / 1ps

module tb;

    import u16u8_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       str_end;
    } utf8_byte_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_we      = 1'b0;
    logic        cfg_wdata   = 1'b0;
    logic        s_valid     = 1'b0;
    logic [15:0] s_code_unit = 16'h0000;
    logic        m_ready     = 1'b0;
    wire         s_ready;
    wire         m_valid;
    wire  [7:0]  m_out_byte;
    wire         m_last;
    wire         m_string_end;

    // Words waiting to be driven, and the UTF-8 bytes expected back.
    logic [15:0] pending_units[$];
    utf8_byte_t  utf8_q[$];
    utf8_byte_t  burst_q[$];
    utf8_byte_t  want;
    utf8_byte_t  nb;

    // Predictor state and its copy of the swap control.
    logic        cfg_swap   = 1'b1;
    logic        hold_valid = 1'b0;
    logic [15:0] held_unit  = 16'h0000;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int queued_cnt    = 0;
    int accepted_cnt  = 0;
    int fail_count    = 0;

    utf16_to_utf8_transcoder_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_unit (s_code_unit),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last      (m_last),
        .m_string_end(m_string_end)
    );

    always #10 aclk = ~aclk;

    function automatic logic [15:0] swap16(input logic [15:0] x);
        return {x[7:0], x[15:8]};
    endfunction

    task automatic add_burst(input logic [7:0] data, input logic str_end);
        utf8_byte_t b;
        b.data    = data;
        b.last    = 1'b0;
        b.str_end = str_end;
        burst_q.push_back(b);
    endtask

    task automatic add_three(input logic [15:0] x);
        add_burst({4'b1110, x[15:12]}, 1'b0);
        add_burst({2'b10, x[11:6]}, 1'b0);
        add_burst({2'b10, x[5:0]}, 1'b0);
    endtask

    // Computes the bytes that one accepted word produces and queues them.
    task automatic transcode_unit(input logic [15:0] raw);
        logic [15:0] u;
        logic [20:0] cp;
        logic        new_hold;
        u = cfg_swap ? swap16(raw) : raw;
        new_hold = 1'b0;
        burst_q.delete();
        if (hold_valid && (u & MASK_SURR) == LOW_SURR) begin
            cp = 21'h10000 + {held_unit[9:0], u[9:0]};
            add_burst({5'b11110, cp[20:18]}, 1'b0);
            add_burst({2'b10, cp[17:12]}, 1'b0);
            add_burst({2'b10, cp[11:6]}, 1'b0);
            add_burst({2'b10, cp[5:0]}, 1'b0);
        end else begin
            // A held high surrogate with no low partner goes out on its own.
            if (hold_valid)
                add_three(held_unit);
            if (u == 16'h0000)
                add_burst(8'h00, 1'b1);
            else if ((u & MASK_ONE) == 16'h0000)
                add_burst(u[7:0], 1'b0);
            else if ((u & MASK_TWO) == 16'h0000) begin
                add_burst({3'b110, u[10:6]}, 1'b0);
                add_burst({2'b10, u[5:0]}, 1'b0);
            end else if ((u & MASK_SURR) == HIGH_SURR)
                new_hold = 1'b1;
            else
                add_three(u);
        end
        hold_valid = new_hold;
        held_unit  = new_hold ? u : 16'h0000;
        for (int i = 0; i < burst_q.size(); i++) begin
            nb      = burst_q[i];
            nb.last = (i == burst_q.size() - 1);
            utf8_q.push_back(nb);
        end
    endtask

    // Driver: predicts on acceptance, then loads the next word or idles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                transcode_unit(s_code_unit);
                accepted_cnt++;
            end
            if (!s_valid || s_ready) begin
                if (pending_units.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid     <= 1'b1;
                    s_code_unit <= pending_units.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted byte against the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (utf8_q.size() == 0) begin
                    $display("%0t: unexpected byte, expected none, actual data=%h last=%b end=%b",
                             $time, m_out_byte, m_last, m_string_end);
                    fail_count++;
                end else begin
                    want = utf8_q.pop_front();
                    if (m_out_byte !== want.data) begin
                        $display("%0t: out_byte mismatch, expected %h, actual %h",
                                 $time, want.data, m_out_byte);
                        fail_count++;
                    end
                    if (m_last !== want.last) begin
                        $display("%0t: last mismatch, expected %b, actual %b",
                                 $time, want.last, m_last);
                        fail_count++;
                    end
                    if (m_string_end !== want.str_end) begin
                        $display("%0t: string_end mismatch, expected %b, actual %b",
                                 $time, want.str_end, m_string_end);
                        fail_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_unit(input logic [15:0] value);
        pending_units.push_back(cfg_swap ? swap16(value) : value);
        queued_cnt++;
    endtask

    task automatic send_directed();
        logic [15:0] units[$];
        units = '{16'h0041, 16'h0000, 16'h0001, 16'h007F, 16'h0080, 16'h07FF,
                  16'h0800, 16'hFFFF, 16'hD7FF, 16'hE000,
                  16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF, 16'hD83D, 16'hDE00,
                  16'hDC00,
                  16'hD800, 16'h0041,
                  16'hD801, 16'h07FF,
                  16'hDABC, 16'h0800,
                  16'hD800, 16'hDBFF, 16'hDC00,
                  16'hD800, 16'h0000};
        foreach (units[i])
            send_unit(units[i]);
    endtask

    // Mostly well-formed text with surrogate pairs, plus broken pairs and noise.
    task automatic send_random(input int count);
        int k;
        int pick;
        k = 0;
        while (k < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                send_unit(16'($urandom_range(16'h0001, 16'h007F)));
            end else if (pick < 45) begin
                send_unit(16'($urandom_range(16'h0080, 16'h07FF)));
            end else if (pick < 65) begin
                if ($urandom_range(0, 1))
                    send_unit(16'($urandom_range(16'h0800, 16'hD7FF)));
                else
                    send_unit(16'($urandom_range(16'hE000, 16'hFFFF)));
            end else if (pick < 85) begin
                send_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
                send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
                k++;
            end else if (pick < 90) begin
                send_unit(16'h0000);
            end else if (pick < 95) begin
                send_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
            end else if (pick < 97) begin
                send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end else begin
                send_unit(16'($urandom_range(0, 16'hFFFF)));
            end
            k++;
        end
    endtask

    // Waits until every word is accepted and every byte has come back.
    task automatic drain();
        while (accepted_cnt != queued_cnt || utf8_q.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_swap(input logic value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cfg_swap   = value;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Swap is on out of reset.
        send_idle_pct = 17;
        recv_idle_pct = 81;
        send_directed();
        send_random(100);
        drain();

        write_swap(1'b0);
        send_idle_pct = 81;
        recv_idle_pct = 17;
        send_directed();
        send_random(100);
        drain();

        write_swap(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(120);
        drain();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #10ms;
        $display("Verification failed");
        $finish;
    end

endmodule
